FILE: rtl/fskx_pkg.sv
// ----------------------------------------------------------------------------
// fskx_pkg: shared types and constants of the FASTQ k-mer extractor
// Record phase codes, register map, window packing sizes, sequencer states.
// ----------------------------------------------------------------------------
package fskx_pkg;

  // FASTQ text
  localparam logic [7:0] LINE_END     = 8'd10;
  localparam logic [1:0] SEQ_PHASE    = 2'd3;
  localparam logic [1:0] PHASE_RESET  = 2'd2;

  // Window packing: 32 characters of 8 bits, 8 characters per output word
  localparam int CHAR_W    = 8;
  localparam int MAX_KMER  = 32;
  localparam int WIN_W     = MAX_KMER * CHAR_W;
  localparam int WORD_W    = 64;
  localparam int NUM_WORDS = WIN_W / WORD_W;
  localparam int START_OUT_W = 7;

  // Windows emitted per read at most
  localparam int MAX_RESULTS = 50;
  localparam int NWIN_W      = 6;

  // Stride register
  localparam int          STRIDE_W     = 5;
  localparam int          MAX_STRIDE   = 31;
  localparam logic [4:0]  STRIDE_RESET = 5'd31;
  localparam logic [4:0]  MIN_STRIDE   = 5'd2;

  // Configuration port: register i at byte address 4*i
  localparam int         CFG_ADDR_W     = 3;
  localparam int         CFG_DATA_W     = 32;
  localparam logic [0:0] CFG_IDX_STRIDE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PLAN   = 4'b0010,
    ST_GATHER = 4'b0100,
    ST_EMIT   = 4'b1000
  } fskx_state_t;

endpackage

FILE: rtl/fskx_in_if.sv
// ----------------------------------------------------------------------------
// fskx_in_if: text byte channel
// One FASTQ text byte per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fskx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

FILE: rtl/fskx_out_if.sv
// ----------------------------------------------------------------------------
// fskx_out_if: k-mer window channel
// One packed window per beat, with start position and read flags.
// ----------------------------------------------------------------------------
interface fskx_out_if;
  import fskx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [WORD_W-1:0]      kmer_word_0;
  logic [WORD_W-1:0]      kmer_word_1;
  logic [WORD_W-1:0]      kmer_word_2;
  logic [WORD_W-1:0]      kmer_word_3;
  logic [START_OUT_W-1:0] window_start;
  logic                   last_of_read;
  logic                   read_truncated;

  modport source (output valid, output kmer_word_0, output kmer_word_1,
                  output kmer_word_2, output kmer_word_3, output window_start,
                  output last_of_read, output read_truncated, input ready);
  modport sink   (input valid, input kmer_word_0, input kmer_word_1,
                  input kmer_word_2, input kmer_word_3, input window_start,
                  input last_of_read, input read_truncated, output ready);
endinterface

FILE: rtl/fastq_strided_kmer_extractor_top.sv
// ----------------------------------------------------------------------------
// fastq_strided_kmer_extractor_top: strided k-mer windows from FASTQ text
// Buffers each sequence line and, at its line end, sends strided windows
// plus one tail window, packed eight characters per word.
// ----------------------------------------------------------------------------
// Throughput: bytes that do not end a sequence line stream back to back. A
//   sequence line end of a long enough read runs, per emitted window, plan,
//   KMER_LEN reads through the single read port of the read buffer and its
//   registered data, then a load of the output that waits on a stalled sink.
//   No byte is taken until the last window of the read is loaded.
// Reset: synchronous, active low; record phase expects a header line, read
//   length, overflow flag and output valid clear, stride returns to 31.
// ----------------------------------------------------------------------------
module fastq_strided_kmer_extractor_top #(
  parameter int MAX_READ = 128,
  parameter int KMER_LEN = 31
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fskx_in_if.sink                         in_chan,
  fskx_out_if.source                      out_chan,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fskx_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [fskx_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [fskx_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import fskx_pkg::*;

  // Buffer index, length (holds MAX_READ itself), window start arithmetic
  // (a strided start may overshoot the read by up to one stride).
  localparam int ADDR_W  = $clog2(MAX_READ);
  localparam int LEN_W   = $clog2(MAX_READ + 1);
  localparam int START_W = $clog2(MAX_READ + MAX_STRIDE + 1);
  localparam int CNT_W   = $clog2(KMER_LEN + 1);
  // Characters shift in at the top; align character 0 to the low byte.
  localparam int ALIGN_SHIFT = CHAR_W * (MAX_KMER - KMER_LEN);

  fskx_state_t state_r, state_nxt;

  // Record tracking
  logic [1:0]         phase_r;
  logic [LEN_W-1:0]   len_r;
  logic               ovf_r;
  logic [STRIDE_W-1:0] stride_r;

  // Read buffer
  logic [CHAR_W-1:0]  mem [MAX_READ];
  logic [CHAR_W-1:0]  rd_data_r;

  // Window sequencer
  logic [START_W-1:0] start_r;
  logic [START_W-1:0] next_start_r;
  logic [START_W-1:0] lmk_r;      // read length minus KMER_LEN: tail start
  logic               is_tail_r;
  logic               next_tail_r;
  logic               last_r;
  logic [NWIN_W-1:0]  nwin_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               rd_vld_r;
  logic [WIN_W-1:0]   win_r;
  logic [WIN_W-1:0]   win_aligned;

  // Output register
  logic                   out_valid_r;
  logic [WORD_W-1:0]      out_word_r [NUM_WORDS];
  logic [START_OUT_W-1:0] out_start_r;
  logic                   out_last_r;
  logic                   out_trunc_r;

  // Shared adder: start + stride while planning, start + offset while reading
  logic [STRIDE_W-1:0] stride_eff;
  logic [START_W-1:0]  add_b;
  logic [START_W-1:0]  sum;

  logic in_fire;
  logic is_nl;
  logic in_seq;
  logic out_free;
  logic out_load;
  logic cfg_wr;
  logic len_ge_k;
  logic buf_room;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire  = in_chan.valid & in_chan.ready;
  assign is_nl    = (in_chan.text_byte == LINE_END);
  assign in_seq   = (phase_r == SEQ_PHASE);
  assign out_free = ~out_valid_r | out_chan.ready;
  assign out_load = (state_r == ST_EMIT) & out_free;
  assign len_ge_k = (len_r >= LEN_W'(KMER_LEN));
  assign buf_room = (len_r < LEN_W'(MAX_READ));

  // Stride below the minimum acts as the minimum
  assign stride_eff = (stride_r < MIN_STRIDE) ? MIN_STRIDE : stride_r;
  assign add_b = (state_r == ST_PLAN) ? START_W'(stride_eff) : START_W'(cnt_r);
  assign sum   = start_r + add_b;

  assign win_aligned = win_r >> ALIGN_SHIFT;

  // Configuration port: byte address bit 2 selects the register
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite &
                  (cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_STRIDE);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_STRIDE) ?
                      CFG_DATA_W'(stride_r) : '0;

  // Result channel
  assign out_chan.valid          = out_valid_r;
  assign out_chan.kmer_word_0    = out_word_r[0];
  assign out_chan.kmer_word_1    = out_word_r[1];
  assign out_chan.kmer_word_2    = out_word_r[2];
  assign out_chan.kmer_word_3    = out_word_r[3];
  assign out_chan.window_start   = out_start_r;
  assign out_chan.last_of_read   = out_last_r;
  assign out_chan.read_truncated = out_trunc_r;

  // Read buffer: write sequence bytes at the fill position, read one
  // character per cycle at the address from the shared adder.
  always_ff @(posedge clk) begin
    if (in_fire && !is_nl && in_seq && buf_room) begin
      mem[len_r[ADDR_W-1:0]] <= in_chan.text_byte;
    end
    rd_data_r <= mem[sum[ADDR_W-1:0]];
  end

  // Sequencer: idle takes bytes; a sequence line end of a long enough read
  // loops plan -> gather -> emit once per window.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_nl && in_seq && len_ge_k) state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        state_nxt = ST_GATHER;
      end
      ST_GATHER: begin
        if (cnt_r == CNT_W'(KMER_LEN) && rd_vld_r) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = last_r ? ST_IDLE : ST_PLAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PHASE_RESET;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      stride_r    <= STRIDE_RESET;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        stride_r <= cfg_pwdata[STRIDE_W-1:0];
      end

      // Raise valid on a load, drop it once the beat is taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_nl) begin
              if (in_seq) begin
                phase_r <= 2'd0;
                if (len_ge_k) begin
                  // Hold length and overflow until the last window leaves
                  start_r   <= '0;
                  is_tail_r <= 1'b0;
                  nwin_r    <= '0;
                  lmk_r     <= START_W'(len_r) - START_W'(KMER_LEN);
                end else begin
                  len_r <= '0;
                  ovf_r <= 1'b0;
                end
              end else begin
                phase_r <= phase_r + 2'd1;
              end
            end else if (in_seq) begin
              if (buf_room) begin
                len_r <= len_r + LEN_W'(1);
              end else begin
                ovf_r <= 1'b1;
              end
            end
          end
        end

        ST_PLAN: begin
          // Decide what follows this window so the last flag goes out with it:
          // another strided window if it fits, else a tail if the next start
          // still lies in the read, else nothing; at most MAX_RESULTS windows.
          next_start_r <= sum;
          next_tail_r  <= !(sum <= lmk_r);
          last_r       <= is_tail_r ||
                          (nwin_r >= NWIN_W'(MAX_RESULTS - 1)) ||
                          !(sum < START_W'(len_r));
          cnt_r        <= '0;
          rd_vld_r     <= 1'b0;
        end

        ST_GATHER: begin
          // Issue one read per cycle, shift its registered data in on the next cycle
          if (cnt_r < CNT_W'(KMER_LEN)) begin
            cnt_r    <= cnt_r + CNT_W'(1);
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r) begin
            win_r <= {rd_data_r, win_r[WIN_W-1:CHAR_W]};
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            for (int j = 0; j < NUM_WORDS; j++) begin
              out_word_r[j] <= win_aligned[j*WORD_W +: WORD_W];
            end
            out_start_r <= start_r[START_OUT_W-1:0];
            out_last_r  <= last_r;
            out_trunc_r <= ovf_r;
            if (last_r) begin
              len_r <= '0;
              ovf_r <= 1'b0;
            end else begin
              start_r   <= next_tail_r ? lmk_r : next_start_r;
              is_tail_r <= next_tail_r;
              nwin_r    <= nwin_r + NWIN_W'(1);
            end
          end
        end

        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/fskx_checker.sv
// ----------------------------------------------------------------------------
// fskx_checker: port-level checks of the k-mer extractor
// Watches the byte and window channels; bound to the top level.
// ----------------------------------------------------------------------------
module fskx_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [7:0]                        in_text_byte,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [fskx_pkg::WORD_W-1:0]       out_word_0,
  input logic [fskx_pkg::WORD_W-1:0]       out_word_3,
  input logic [fskx_pkg::START_OUT_W-1:0]  out_window_start,
  input logic                              out_last_of_read
);
  import fskx_pkg::*;

  // Hold a stalled window beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_0) &&
      $stable(out_word_3) && $stable(out_window_start) &&
      $stable(out_last_of_read))
    else $error("stalled window beat changed");

  // Bytes other than line ends never stall the byte channel
  a_plain_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_text_byte != LINE_END) |=> in_ready)
    else $error("plain byte stalled the input");

  // While windows of a read remain, no byte is taken
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_read |-> !in_ready)
    else $error("byte taken while read windows pending");

  // Reset clears the window channel
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("window valid after reset");

endmodule

bind fastq_strided_kmer_extractor_top fskx_checker u_fskx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_text_byte     (in_chan.text_byte),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_word_0       (out_chan.kmer_word_0),
  .out_word_3       (out_chan.kmer_word_3),
  .out_window_start (out_chan.window_start),
  .out_last_of_read (out_chan.last_of_read)
);

FILE: tb/sv/fskx_window_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fskx_window_checker: scoreboard for the FASTQ k-mer extractor
// Follows the record phase and read buffer from the text beats, rebuilds the
// strided and tail windows at each sequence line end, and compares every
// window beat against the oldest pending window.
// ----------------------------------------------------------------------------
module fskx_window_checker
  import fskx_pkg::*;
#(
  parameter int MAX_READ = 128,
  parameter int KMER_LEN = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fskx_in_if                    text_mon,
  fskx_out_if                   win_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    mismatches,
  output int                    outstanding
);

  // record phase right after a sequence line end
  localparam logic [1:0] PHASE_AFTER_SEQ = 2'd0;

  typedef struct {
    logic [WIN_W-1:0]       chars;
    logic [START_OUT_W-1:0] first;
    logic                   last;
    logic                   trunc;
  } window_t;

  window_t              pending_windows[$];
  logic [1:0]           rec_phase;
  logic [CHAR_W-1:0]    seq_buf[MAX_READ];
  int                   seq_len;
  logic                 seq_dropped;
  logic [STRIDE_W-1:0]  stride_reg;

  // Build every window of the finished read, in emission order.
  function automatic void queue_read_windows();
    int      step;
    int      n;
    int      i;
    int      pos;
    int      starts[MAX_RESULTS];
    window_t w;

    step = (stride_reg < MIN_STRIDE) ? int'(MIN_STRIDE) : int'(stride_reg);
    if (seq_len < KMER_LEN) return;
    n = 0;
    i = 0;
    while (i + KMER_LEN <= seq_len && n < MAX_RESULTS) begin
      starts[n] = i;
      n++;
      i += step;
    end
    // tail window ends on the last base, even if it repeats a strided one
    if (i < seq_len && n < MAX_RESULTS) begin
      starts[n] = seq_len - KMER_LEN;
      n++;
    end
    for (int m = 0; m < n; m++) begin
      w.chars = '0;
      for (int c = 0; c < KMER_LEN && c < MAX_KMER; c++) begin
        pos = starts[m] + c;
        if (pos < MAX_READ) w.chars[c*CHAR_W +: CHAR_W] = seq_buf[pos];
      end
      w.first = START_OUT_W'(starts[m]);
      w.last  = (m == n - 1);
      w.trunc = seq_dropped;
      pending_windows.insert(pending_windows.size(), w);
    end
  endfunction

  function automatic void take_text_byte(input logic [7:0] b);
    if (b == LINE_END) begin
      if (rec_phase == SEQ_PHASE) begin
        queue_read_windows();
        rec_phase   = PHASE_AFTER_SEQ;
        seq_len     = 0;
        seq_dropped = 1'b0;
      end else begin
        rec_phase = rec_phase + 2'd1;
      end
    end else if (rec_phase == SEQ_PHASE) begin
      if (seq_len < MAX_READ) begin
        seq_buf[seq_len] = b;
        seq_len++;
      end else begin
        seq_dropped = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    window_t          exp_w;
    logic [WIN_W-1:0] got_chars;
    logic             bad;

    if (!rst_n) begin
      rec_phase   = PHASE_RESET;
      seq_len     = 0;
      seq_dropped = 1'b0;
      stride_reg  = STRIDE_RESET;
      foreach (seq_buf[k]) seq_buf[k] = '0;
      pending_windows.delete();
      mismatches   = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == CFG_IDX_STRIDE)
        stride_reg = cfg_pwdata[STRIDE_W-1:0];

      if (text_mon.valid && text_mon.ready) take_text_byte(text_mon.text_byte);

      if (win_mon.valid && win_mon.ready) begin
        got_chars = {win_mon.kmer_word_3, win_mon.kmer_word_2,
                     win_mon.kmer_word_1, win_mon.kmer_word_0};
        if (pending_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected window: start=%0d last=%b trunc=%b chars=%h",
                     win_mon.window_start, win_mon.last_of_read,
                     win_mon.read_truncated, got_chars);
        end else begin
          exp_w = pending_windows.pop_front();
          bad = 1'b0;
          for (int j = 0; j < NUM_WORDS; j++)
            if (got_chars[j*WORD_W +: WORD_W] !== exp_w.chars[j*WORD_W +: WORD_W])
              bad = 1'b1;
          if (win_mon.window_start !== exp_w.first) bad = 1'b1;
          if (win_mon.last_of_read !== exp_w.last) bad = 1'b1;
          if (win_mon.read_truncated !== exp_w.trunc) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("window mismatch, exp: start=%0d last=%b trunc=%b chars=%h",
                       exp_w.first, exp_w.last, exp_w.trunc, exp_w.chars);
              $display("window mismatch, got: start=%0d last=%b trunc=%b chars=%h",
                       win_mon.window_start, win_mon.last_of_read,
                       win_mon.read_truncated, got_chars);
            end
          end
        end
      end
    end
    outstanding = pending_windows.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the FASTQ k-mer extractor
// Streams FASTQ records byte by byte (directed reads around the window edge
// cases, then random reads, noise and broken records) under several stride
// settings, with bursty input and a stalling window sink. The checker beside
// the block predicts and compares every window beat.
// ----------------------------------------------------------------------------
module tb_top;
  import fskx_pkg::*;

  localparam int MAX_READ    = 128;
  localparam int KMER_LEN    = 31;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS       = 320;

  typedef enum int {TXT_PRINT, TXT_BASES, TXT_ANY, TXT_EDGE} text_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches;
  int outstanding;

  // sender state: beats left in the current burst, lines and beats sent
  int burst_left;
  int lines_sent;
  int beats_sent;
  // long sink hold-offs asked by the stimulus and served by the sink
  int hold_requests;
  int holds_done;

  fskx_in_if  text_if ();
  fskx_out_if win_if ();

  fastq_strided_kmer_extractor_top #(
    .MAX_READ(MAX_READ),
    .KMER_LEN(KMER_LEN)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (text_if),
    .out_chan   (win_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  fskx_window_checker #(
    .MAX_READ(MAX_READ),
    .KMER_LEN(KMER_LEN)
  ) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_mon    (text_if),
    .win_mon     (win_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Bail out if the run hangs: the slowest legal run is far below this.
  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Pick one text character of the given kind; never a line end.
  function automatic logic [7:0] pick_char(input text_kind_t kind, input int idx);
    logic [39:0] bases;
    logic [7:0]  b;

    bases = "ACGTN";
    b = 8'h41;
    case (kind)
      TXT_PRINT: b = 8'($urandom_range(33, 126));
      TXT_BASES: b = bases[8*$urandom_range(0, 4) +: 8];
      TXT_ANY: begin
        do b = 8'($urandom_range(0, 255)); while (b == LINE_END);
      end
      TXT_EDGE: begin
        // cycle through all-zero, all-one and random bytes
        if (idx % 3 == 0) b = 8'h00;
        else if (idx % 3 == 1) b = 8'hFF;
        else do b = 8'($urandom_range(0, 255)); while (b == LINE_END);
      end
      default: b = 8'h41;
    endcase
    return b;
  endfunction

  // Offer one text beat and hold it until accepted. A new burst starts with
  // a random gap, and now and then a long burst runs without any gap.
  task automatic push_byte(input logic [7:0] b);
    int gap;

    @(negedge clk);
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
        burst_left = $urandom_range(60, 120);
      end else begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        text_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    text_if.valid     = 1'b1;
    text_if.text_byte = b;
    burst_left--;
    do @(posedge clk); while (!text_if.ready);
    beats_sent++;
  endtask

  task automatic send_line(input int n, input text_kind_t kind);
    for (int i = 0; i < n; i++) push_byte(pick_char(kind, i));
    push_byte(LINE_END);
    lines_sent++;
  endtask

  // One well-formed record: short header, sequence, separator, short quality.
  task automatic send_record(input int seq_n, input text_kind_t kind);
    send_line($urandom_range(1, 4), TXT_PRINT);
    send_line(seq_n, kind);
    send_line($urandom_range(0, 1), TXT_PRINT);
    send_line($urandom_range(0, 4), TXT_PRINT);
  endtask

  // Broken record: random lines of random bytes, then empty lines until the
  // next line falls on a header again.
  task automatic send_noise();
    int n_lines;

    n_lines = $urandom_range(1, 3);
    repeat (n_lines) send_line($urandom_range(0, 20), TXT_ANY);
    while (lines_sent % 4 != 0) send_line(0, TXT_PRINT);
  endtask

  // Drop valid, wait for every pending window, then let a short read's line
  // end drain through the block before touching the register.
  task automatic wait_idle();
    @(negedge clk);
    text_if.valid = 1'b0;
    wait (outstanding == 0);
    repeat (KMER_LEN + 8) @(negedge clk);
  endtask

  // APB write of the stride register: setup cycle, then access cycle.
  task automatic write_stride(input logic [STRIDE_W-1:0] stride_val);
    wait_idle();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {CFG_IDX_STRIDE, 2'b00};
    cfg_pwdata  = ($urandom() & ~32'h1F) | CFG_DATA_W'(stride_val);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Mostly reads a little over one window, some short, some past the buffer.
  function automatic int pick_read_len();
    int r;

    r = $urandom_range(0, 19);
    if (r < 2) return $urandom_range(0, KMER_LEN - 1);
    if (r < 4) return $urandom_range(MAX_READ, MAX_READ + 30);
    if (r == 4) return $urandom_range(0, 1) ? KMER_LEN : MAX_READ;
    return $urandom_range(KMER_LEN, 64);
  endfunction

  function automatic logic [STRIDE_W-1:0] pick_stride();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return STRIDE_W'(1);
      2: return MIN_STRIDE;
      3: return STRIDE_W'(MAX_STRIDE);
      default: return STRIDE_W'($urandom_range(3, MAX_STRIDE - 1));
    endcase
  endfunction

  // Window sink: ready follows a pattern picked anew when its age runs out,
  // sometimes with no stalls at all; a requested hold-off keeps ready low for
  // a long stretch so the block backs up onto the text input.
  initial begin : win_sink
    logic [15:0] pat;
    int          age;

    win_if.ready = 1'b0;
    pat = '1;
    age = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        win_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      if (age == 0) begin
        case ($urandom_range(0, 3))
          0: pat = '1;
          1: pat = 16'($urandom()) | 16'h0101;
          2: pat = 16'hAAAA;
          default: pat = 16'($urandom()) | 16'h8000;
        endcase
        age = 48;
      end
      age--;
      win_if.ready = pat[age % 16];
    end
  end

  initial begin : stim
    int rnd;

    rst_n             = 1'b0;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    burst_left        = 0;
    lines_sent        = 0;
    beats_sent        = 0;
    hold_requests     = 0;
    holds_done        = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed reads at the reset stride.
    send_record(KMER_LEN, TXT_BASES);       // exactly one window
    send_record(KMER_LEN - 1, TXT_BASES);   // too short: nothing
    send_record(MAX_READ + 2, TXT_EDGE);    // overflow with tail, 00 and FF bytes

    // Stride below the minimum acts as 2 and the tail repeats the last
    // strided window; a long sink hold-off backs the block onto the input.
    write_stride('0);
    hold_requests++;
    send_record(KMER_LEN + 4, TXT_BASES);   // flag clears on the next read

    // Random part: reads, noise, stride changes and pauses.
    while (beats_sent < ITEMS) begin
      rnd = $urandom_range(0, 15);
      if (rnd < 9) begin
        send_record(pick_read_len(), (rnd < 2) ? TXT_ANY : TXT_BASES);
      end else if (rnd < 11) begin
        send_noise();
      end else if (rnd < 13) begin
        write_stride(pick_stride());
      end else if (rnd == 13) begin
        hold_requests++;
        send_record(pick_read_len(), TXT_BASES);
      end else begin
        // pause the text stream until every window is out
        wait_idle();
      end
    end

    // Drain, then leave room for any stray window to show up.
    wait_idle();
    repeat (2 * (KMER_LEN + 3)) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
